[src/ioppt_pkg.sv]
// Shared types and constants for the I/O pattern prefetch tuner.
// No dependencies; used by ioppt_pair_tracker and the top level.
package ioppt_pkg;

  localparam int HISTORY_DEPTH = 32;
  localparam int PTR_W         = $clog2(HISTORY_DEPTH);
  localparam int CNT_W         = $clog2(HISTORY_DEPTH);
  localparam int CFG_W         = 8;
  localparam int CMP_W         = (CNT_W + 1 > CFG_W) ? CNT_W + 1 : CFG_W;
  localparam int INODE_W       = 16;
  localparam int BLOCK_W       = 24;
  localparam int CLASS_W       = 2;
  localparam int CFG_IDX_W     = 2;

  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  localparam logic [CLASS_W-1:0] CLS_SEQ   = 2'd0;
  localparam logic [CLASS_W-1:0] CLS_RAND  = 2'd1;
  localparam logic [CLASS_W-1:0] CLS_MIXED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_PAIRS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEQ_WINDOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIX_WINDOW = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RND_WINDOW = 2'd3;

  localparam logic [CFG_W-1:0] RST_MIN_PAIRS  = 8'd10;
  localparam logic [CFG_W-1:0] RST_SEQ_WINDOW = 8'd10;
  localparam logic [CFG_W-1:0] RST_MIX_WINDOW = 8'd3;
  localparam logic [CFG_W-1:0] RST_RND_WINDOW = 8'd0;

  typedef enum logic [1:0] {
    PC_SKIP  = 2'd0,
    PC_OTHER = 2'd1,
    PC_SEQ   = 2'd2,
    PC_RAND  = 2'd3
  } pair_code_t;

  typedef struct packed {
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] seq;
    logic [CNT_W-1:0] rnd;
  } pair_counts_t;

endpackage

[src/ioppt_pair_tracker.sv]
// Running pair counts over the request ring: one class code per neighbor pair.
// Depends on ioppt_pkg.
module ioppt_pair_tracker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         rec_en,
  input  logic [ioppt_pkg::INODE_W-1:0] rec_inode,
  input  logic [ioppt_pkg::BLOCK_W-1:0] rec_block,
  output ioppt_pkg::pair_counts_t       counts
);

  localparam int DEPTH = ioppt_pkg::HISTORY_DEPTH;
  localparam int CW    = ioppt_pkg::CNT_W;

  ioppt_pkg::pair_code_t            code_r [DEPTH];
  logic [ioppt_pkg::PTR_W-1:0]      wp_r, wp_nxt, prev_idx;
  logic [ioppt_pkg::INODE_W-1:0]    newest_inode_r;
  logic [ioppt_pkg::BLOCK_W-1:0]    newest_block_r;
  ioppt_pkg::pair_counts_t          counts_r, counts_nxt;
  ioppt_pkg::pair_code_t            new_code, old_code;
  logic [ioppt_pkg::BLOCK_W:0]      diff;

  always_comb begin
    diff = {1'b0, rec_block} - {1'b0, newest_block_r};
    if (newest_inode_r == '0 || rec_inode == '0) begin
      new_code = ioppt_pkg::PC_SKIP;
    end else if (newest_inode_r != rec_inode) begin
      new_code = ioppt_pkg::PC_OTHER;
    end else if (diff == (ioppt_pkg::BLOCK_W+1)'(1)) begin
      new_code = ioppt_pkg::PC_SEQ;
    end else if (diff == '0 || diff == '1) begin
      new_code = ioppt_pkg::PC_OTHER;
    end else begin
      new_code = ioppt_pkg::PC_RAND;
    end
  end

  always_comb begin
    prev_idx = (wp_r == '0) ? ioppt_pkg::PTR_W'(DEPTH - 1) : wp_r - 1'b1;
    wp_nxt   = (wp_r == ioppt_pkg::PTR_W'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    old_code = code_r[wp_r];
    // add the pair ending in the new entry, drop the pair now closing the ring
    counts_nxt.total = counts_r.total + CW'(new_code != ioppt_pkg::PC_SKIP)
                       - CW'(old_code != ioppt_pkg::PC_SKIP);
    counts_nxt.seq   = counts_r.seq + CW'(new_code == ioppt_pkg::PC_SEQ)
                       - CW'(old_code == ioppt_pkg::PC_SEQ);
    counts_nxt.rnd   = counts_r.rnd + CW'(new_code == ioppt_pkg::PC_RAND)
                       - CW'(old_code == ioppt_pkg::PC_RAND);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r           <= '0;
      newest_inode_r <= '0;
      counts_r       <= '0;
      for (int i = 0; i < DEPTH; i++) begin
        code_r[i] <= ioppt_pkg::PC_SKIP;
      end
    end else if (rec_en) begin
      wp_r             <= wp_nxt;
      newest_inode_r   <= rec_inode;
      counts_r         <= counts_nxt;
      code_r[prev_idx] <= new_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_en) begin
      newest_block_r <= rec_block;
    end
  end

  assign counts = counts_r;

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    counts_r.total <= CW'(DEPTH - 1))
    else $error("pair total above ring size");

  a_class_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, counts_r.seq} + {1'b0, counts_r.rnd}) <= {1'b0, counts_r.total})
    else $error("classified pairs exceed total");

  a_record_moves_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    rec_en |=> wp_r != $past(wp_r))
    else $error("write pointer did not advance on record");

endmodule

[src/io_pattern_prefetch_tuner_unit.sv]
// Top level of the I/O pattern prefetch tuner: handshake, registers, classification.
// Depends on ioppt_pkg and ioppt_pair_tracker.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_kind, in_inode, in_block_number
//   out      output     out_valid/out_stall  out_prefetch_blocks, out_workload_class
//   cfg      input      cfg_write_en         cfg_index, cfg_data
//
// One item per cycle unless stalled; a query goes via the input then the result register.
// Records pass through the input register without waiting and give no result.
// A query in the input register waits only while the result register is full and stalled.
// Reset (synchronous, active low) empties the ring and restores register defaults.
module io_pattern_prefetch_tuner_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_kind,
  input  logic [ioppt_pkg::INODE_W-1:0]    in_inode,
  input  logic [ioppt_pkg::BLOCK_W-1:0]    in_block_number,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [ioppt_pkg::CFG_W-1:0]      out_prefetch_blocks,
  output logic [ioppt_pkg::CLASS_W-1:0]    out_workload_class,
  input  logic                             cfg_write_en,
  input  logic [ioppt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ioppt_pkg::CFG_W-1:0]      cfg_data
);

  localparam int CMPW = ioppt_pkg::CMP_W;

  logic [ioppt_pkg::CFG_W-1:0]   min_pairs_r, seq_win_r, mix_win_r, rnd_win_r;
  logic                          s1_valid_r, s1_kind_r;
  logic [ioppt_pkg::INODE_W-1:0] s1_inode_r;
  logic [ioppt_pkg::BLOCK_W-1:0] s1_block_r;
  logic                          out_valid_r;
  logic [ioppt_pkg::CFG_W-1:0]   out_win_r, cur_win_r, win_nxt;
  logic [ioppt_pkg::CLASS_W-1:0] out_cls_r, cur_cls_r, cls_nxt;
  logic                          out_free, s1_adv, s1_query, rec_en, in_xfer;
  ioppt_pkg::pair_counts_t       counts;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_query = s1_valid_r && (s1_kind_r == ioppt_pkg::KIND_QUERY);
  assign s1_adv   = s1_valid_r && (!s1_query || out_free);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_xfer  = in_valid && !in_stall;
  assign rec_en   = s1_valid_r && (s1_kind_r == ioppt_pkg::KIND_RECORD);

  ioppt_pair_tracker u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_en    (rec_en),
    .rec_inode (s1_inode_r),
    .rec_block (s1_block_r),
    .counts    (counts)
  );

  always_comb begin
    if (CMPW'(counts.total) < CMPW'(min_pairs_r)) begin
      cls_nxt = ioppt_pkg::CLS_MIXED;
      win_nxt = cur_win_r;
    end else if (CMPW'(counts.seq) > (CMPW'(counts.rnd) << 1)) begin
      cls_nxt = ioppt_pkg::CLS_SEQ;
      win_nxt = seq_win_r;
    end else if (CMPW'(counts.rnd) > (CMPW'(counts.seq) << 1)) begin
      cls_nxt = ioppt_pkg::CLS_RAND;
      win_nxt = rnd_win_r;
    end else begin
      cls_nxt = ioppt_pkg::CLS_MIXED;
      win_nxt = mix_win_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_pairs_r <= ioppt_pkg::RST_MIN_PAIRS;
      seq_win_r   <= ioppt_pkg::RST_SEQ_WINDOW;
      mix_win_r   <= ioppt_pkg::RST_MIX_WINDOW;
      rnd_win_r   <= ioppt_pkg::RST_RND_WINDOW;
    end else if (cfg_write_en) begin
      case (cfg_index)
        ioppt_pkg::REG_MIN_PAIRS:  min_pairs_r <= cfg_data;
        ioppt_pkg::REG_SEQ_WINDOW: seq_win_r   <= cfg_data;
        ioppt_pkg::REG_MIX_WINDOW: mix_win_r   <= cfg_data;
        ioppt_pkg::REG_RND_WINDOW: rnd_win_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cur_win_r   <= ioppt_pkg::RST_MIX_WINDOW;
      cur_cls_r   <= ioppt_pkg::CLS_MIXED;
    end else begin
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_query && out_free) begin
        out_valid_r <= 1'b1;
        cur_win_r   <= win_nxt;
        cur_cls_r   <= cls_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_kind_r  <= in_kind;
      s1_inode_r <= in_inode;
      s1_block_r <= in_block_number;
    end
    if (s1_query && out_free) begin
      out_win_r <= win_nxt;
      out_cls_r <= cls_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_prefetch_blocks = out_win_r;
  assign out_workload_class  = out_cls_r;

  a_query_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_query && out_free) |=> out_valid_r)
    else $error("query left input register without a result");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_query)
    else $error("input stalled with no query waiting");

  a_class_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_cls_r == ioppt_pkg::CLS_SEQ || out_cls_r == ioppt_pkg::CLS_RAND ||
                     out_cls_r == ioppt_pkg::CLS_MIXED))
    else $error("illegal workload class on output");

  a_result_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    $past(s1_query && out_free) |-> (out_win_r == cur_win_r && out_cls_r == cur_cls_r))
    else $error("result differs from current window state");

endmodule
